@@ src/rthc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rthc_pkg
// Types, constants and helpers shared by the twelve-hour clock unit.
// ----------------------------------------------------------------------------
package rthc_pkg;

  // Command codes; code 7 is a no-op and handled by the default arm
  typedef enum logic [2:0] {
    CMD_TICK       = 3'd0,
    CMD_SET_TIME   = 3'd1,
    CMD_RESET_TIME = 3'd2,
    CMD_ARM        = 3'd3,
    CMD_CLEAR      = 3'd4,
    CMD_READ_MIN   = 3'd5,
    CMD_INIT       = 3'd6
  } rthc_cmd_e;

  // Timeout status codes
  typedef enum logic [1:0] {
    TO_DISABLED = 2'd0,
    TO_ARMED    = 2'd1,
    TO_FIRED    = 2'd2
  } rthc_tstat_e;

  // Register indexes on the config port
  localparam logic CFG_START_HOUR   = 1'b0;
  localparam logic CFG_START_MINUTE = 1'b1;

  localparam logic [9:0] MS_LAST    = 10'd999;
  localparam logic [5:0] SEC_LAST   = 6'd59;
  localparam logic [5:0] MIN_LAST   = 6'd59;
  localparam logic [3:0] HOUR_LAST  = 4'd12;
  localparam logic [3:0] HOUR_FIRST = 4'd1;
  localparam logic [6:0] SEC_PER_MIN = 7'd60;
  localparam logic [5:0] TO_MIN_SEC = 6'd1;
  localparam logic [5:0] TO_MAX_SEC = 6'd60;

  localparam logic [3:0] RST_START_HOUR   = 4'd12;
  localparam logic [5:0] RST_START_MINUTE = 6'd0;

  // Full clock state; a result word reports all of it but the alarm fields
  typedef struct packed {
    logic [3:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [9:0]  msec;
    logic [31:0] epoch;
    logic [31:0] half_days;
    logic        update;
    rthc_tstat_e tstat;
    logic [5:0]  alarm_sec;
    logic [5:0]  alarm_min;
  } rthc_state_t;

  function automatic logic [3:0] sat_hour(input logic [3:0] h);
    return (h > HOUR_LAST) ? HOUR_LAST : h;
  endfunction

  function automatic logic [5:0] sat_minute(input logic [5:0] m);
    return (m > MIN_LAST) ? MIN_LAST : m;
  endfunction

  // State loaded by reset and by the init command
  function automatic rthc_state_t start_state(input logic [3:0] h, input logic [5:0] m);
    rthc_state_t s;
    s           = '0;
    s.hour      = sat_hour(h);
    s.minute    = sat_minute(m);
    s.update    = 1'b1;
    s.tstat     = TO_DISABLED;
    return s;
  endfunction

endpackage
`default_nettype wire

@@ src/rthc_step.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rthc_step
// Next-state logic: applies one command word to the current clock state.
// ----------------------------------------------------------------------------
module rthc_step (
  input  rthc_pkg::rthc_state_t state_i,
  input  logic [2:0]            cmd_i,
  input  logic [3:0]            hour_in_i,
  input  logic [5:0]            minute_in_i,
  input  logic [5:0]            timeout_seconds_i,
  input  logic [3:0]            start_hour_i,
  input  logic [5:0]            start_minute_i,
  output rthc_pkg::rthc_state_t state_o
);
  import rthc_pkg::*;

  rthc_state_t nxt;
  logic [6:0]  arm_sum;
  logic [6:0]  arm_wrap;

  // Alarm second before and after minute wrap
  assign arm_sum  = {1'b0, timeout_seconds_i} + {1'b0, state_i.second};
  assign arm_wrap = arm_sum - SEC_PER_MIN;

  always_comb begin
    nxt = state_i;
    unique case (cmd_i)
      CMD_TICK: begin
        nxt.epoch = state_i.epoch + 32'd1;
        if (state_i.msec >= MS_LAST) begin
          nxt.msec = '0;
          if (state_i.second >= SEC_LAST) begin
            nxt.second = '0;
            nxt.update = 1'b1;
            if (state_i.minute >= MIN_LAST) begin
              nxt.minute = '0;
              // 12 rolls to 1 and counts a half day
              if (state_i.hour >= HOUR_LAST) begin
                nxt.hour      = HOUR_FIRST;
                nxt.half_days = state_i.half_days + 32'd1;
              end else begin
                nxt.hour = state_i.hour + 4'd1;
              end
            end else begin
              nxt.minute = state_i.minute + 6'd1;
            end
          end else begin
            nxt.second = state_i.second + 6'd1;
          end
          // timeout checked only when seconds advance
          if (state_i.tstat == TO_ARMED && state_i.alarm_min == nxt.minute &&
              state_i.alarm_sec == nxt.second) begin
            nxt.tstat = TO_FIRED;
          end
        end else begin
          nxt.msec = state_i.msec + 10'd1;
        end
      end
      CMD_SET_TIME: begin
        nxt.hour      = sat_hour(hour_in_i);
        nxt.minute    = sat_minute(minute_in_i);
        nxt.second    = '0;
        nxt.half_days = '0;
        nxt.update    = 1'b1;
      end
      CMD_RESET_TIME: begin
        nxt.epoch     = '0;
        nxt.hour      = '0;
        nxt.minute    = '0;
        nxt.second    = '0;
        nxt.half_days = '0;
      end
      CMD_ARM: begin
        if (timeout_seconds_i >= TO_MIN_SEC && timeout_seconds_i <= TO_MAX_SEC) begin
          nxt.tstat = TO_ARMED;
          if (arm_sum >= SEC_PER_MIN) begin
            nxt.alarm_sec = arm_wrap[5:0];
            nxt.alarm_min = state_i.minute + 6'd1;  // may reach 60: never matches
          end else begin
            nxt.alarm_sec = arm_sum[5:0];
            nxt.alarm_min = state_i.minute;
          end
        end
      end
      CMD_CLEAR: begin
        if (state_i.tstat == TO_FIRED) begin
          nxt.tstat = TO_DISABLED;
        end
      end
      CMD_READ_MIN: begin
        nxt.update = 1'b0;
      end
      CMD_INIT: begin
        nxt = start_state(start_hour_i, start_minute_i);
      end
      default: begin
        nxt = state_i;
      end
    endcase
  end

  assign state_o = nxt;

endmodule
`default_nettype wire

@@ src/twelve_hour_clock_with_timeout_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twelve_hour_clock_with_timeout_unit
// Millisecond-ticked 12-hour clock with a one-shot timeout, driven by
// command words.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+----------------------------
//  in      | in        | in_valid_i / in_ready_o   | cmd, hour_in, minute_in,
//          |           |                           | timeout_seconds
//  out     | out       | out_valid_o / out_ready_i | hour .. timeout_status
//  cfg     | in        | cfg_we_i (no wait)        | cfg_idx_i, cfg_wdata_i
//
// One word per cycle sustained while out_ready_i is high; a command taken
// passes the input register, then the state/result register, to the outputs.
// The clock state register doubles as the result register; it only moves
// when the output side is free, so a stalled output holds its word.
// Reset loads hour 12, minute 0, update pending, timeout disabled.
// ----------------------------------------------------------------------------
module twelve_hour_clock_with_timeout_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config port
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [5:0]  cfg_wdata_i,
  // command channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  cmd_i,
  input  logic [3:0]  hour_in_i,
  input  logic [5:0]  minute_in_i,
  input  logic [5:0]  timeout_seconds_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  hour_o,
  output logic [5:0]  minute_o,
  output logic [5:0]  second_o,
  output logic [9:0]  millisecond_o,
  output logic [31:0] epoch_ms_o,
  output logic [31:0] half_day_count_o,
  output logic        update_pending_o,
  output logic [1:0]  timeout_status_o
);
  import rthc_pkg::*;

  logic        in_valid_q;
  logic [2:0]  cmd_q;
  logic [3:0]  hour_in_q;
  logic [5:0]  minute_in_q;
  logic [5:0]  tsec_q;
  logic        out_valid_q;
  logic        advance;
  logic [3:0]  start_hour_q;
  logic [5:0]  start_minute_q;
  rthc_state_t state_q;
  rthc_state_t state_d;

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_hour_q   <= RST_START_HOUR;
      start_minute_q <= RST_START_MINUTE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_START_HOUR:   start_hour_q   <= cfg_wdata_i[3:0];
        CFG_START_MINUTE: start_minute_q <= cfg_wdata_i;
        default:          start_hour_q   <= start_hour_q;
      endcase
    end
  end

  // Word moves from input register to result register when output is free
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // Input register: control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // Input register: payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q       <= cmd_i;
      hour_in_q   <= hour_in_i;
      minute_in_q <= minute_in_i;
      tsec_q      <= timeout_seconds_i;
    end
  end

  rthc_step u_step (
    .state_i           (state_q),
    .cmd_i             (cmd_q),
    .hour_in_i         (hour_in_q),
    .minute_in_i       (minute_in_q),
    .timeout_seconds_i (tsec_q),
    .start_hour_i      (start_hour_q),
    .start_minute_i    (start_minute_q),
    .state_o           (state_d)
  );

  // Clock state / result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= start_state(RST_START_HOUR, RST_START_MINUTE);
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign hour_o           = state_q.hour;
  assign minute_o         = state_q.minute;
  assign second_o         = state_q.second;
  assign millisecond_o    = state_q.msec;
  assign epoch_ms_o       = state_q.epoch;
  assign half_day_count_o = state_q.half_days;
  assign update_pending_o = state_q.update;
  assign timeout_status_o = state_q.tstat;

endmodule
`default_nettype wire
